/* src/sosc_pkg.sv */
// Shared constants, types and the quarter-wave table builder for the sine oscillator.
// Used by sosc_ctrl, sosc_datapath and sine_oscillator_core; depends on nothing else.
package sosc_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int TABLE_BITS  = 10;
   localparam int SAMPLE_BITS = 16;

   localparam int FREQ_BITS       = 16;
   localparam int RATE_BITS       = 18;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 18;
   localparam int FREQ_CLAMP_BITS = 15;
   localparam int DIVIDEND_BITS   = FREQ_CLAMP_BITS + PHASE_BITS;
   localparam int DIV_COUNT_BITS  = $clog2(DIVIDEND_BITS);
   localparam int ROM_ADDR_BITS   = TABLE_BITS + 1;
   localparam int ROM_DEPTH       = (1 << TABLE_BITS) + 1;
   localparam int ENTRY_BITS      = SAMPLE_BITS - 1;
   localparam int REQ_DATA_BITS   = 8;
   localparam int RSP_DATA_BITS   = 2 * SAMPLE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQUENCY   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_RATE = 1'd1;

   localparam logic [FREQ_BITS-1:0] FREQ_RESET     = 16'd440;
   localparam logic [FREQ_BITS-1:0] FREQ_MIN       = 16'd1;
   localparam logic [FREQ_BITS-1:0] FREQ_MAX       = 16'd20000;
   localparam logic [RATE_BITS-1:0] RATE_RESET     = 18'd48000;
   localparam logic [RATE_BITS-1:0] RATE_MIN       = 18'd1;
   localparam logic [63:0]          STEP_RESET_WIDE = (64'd440 << PHASE_BITS) / 64'd48000;
   localparam logic [PHASE_BITS-1:0] STEP_RESET    = STEP_RESET_WIDE[PHASE_BITS-1:0];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] AMP         = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam logic [63:0] ROUND_HALF  = 64'd1 << 29;
   localparam int unsigned TAYLOR_DIV [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

   typedef logic [ENTRY_BITS-1:0] quarter_table_type [0:ROM_DEPTH-1];

   typedef struct packed {
      logic div_init;
      logic div_step;
      logic step_load;
      logic accept;
      logic advance;
   } ctrl_cmd_type;

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type   tbl;
      logic [63:0]         theta;
      logic [63:0]         th2;
      logic [63:0]         term;
      logic [63:0]         scaled;
      logic signed [63:0]  sum;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         theta = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
         th2   = (theta * theta) >> 30;
         term  = theta;
         sum   = signed'(theta);
         for (int n = 1; n < 10; n++) begin
            term = (term * th2) >> 30;
            term = term / 64'(TAYLOR_DIV[n]);
            if ((n % 2) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         scaled = (64'(sum) * AMP + ROUND_HALF) >> 30;
         if (scaled > AMP) begin
            scaled = AMP;
         end
         tbl[k] = scaled[ENTRY_BITS-1:0];
      end
      return tbl;
   endfunction

endpackage

/* src/sosc_ctrl.sv */
// Controller state machine for the sine oscillator: step division sequencing and
// sample pipeline handshakes. Depends on sosc_pkg; drives sosc_datapath by commands.
module sosc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output sosc_pkg::ctrl_cmd_type cmd
);
   import sosc_pkg::*;

   typedef enum logic [3:0] {
      ST_RUN      = 4'b0001,
      ST_DIV_INIT = 4'b0010,
      ST_DIV_RUN  = 4'b0100,
      ST_DIV_LOAD = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic                      stage_valid_ff, stage_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      advance;
   logic                      accept;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_RUN) && advance;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      stage_valid_in = advance ? accept : stage_valid_ff;
      out_valid_in   = advance ? stage_valid_ff : out_valid_ff;
      cmd            = '0;
      cmd.accept     = accept;
      cmd.advance    = advance;
      case (state_ff)
         ST_RUN: begin
            state_in = ST_RUN;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            count_in     = '0;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == DIV_COUNT_BITS'(DIVIDEND_BITS - 1)) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.step_load = 1'b1;
            state_in      = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      if (csr_we) begin
         state_in = ST_DIV_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

endmodule

/* src/sosc_datapath.sv */
// Datapath for the sine oscillator: configuration registers, restoring step divider,
// phase accumulator, quarter-wave ROM and output register. Depends on sosc_pkg.
module sosc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [sosc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sosc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  sosc_pkg::ctrl_cmd_type                cmd,
   input  logic                                  end_of_block,
   output logic signed [sosc_pkg::SAMPLE_BITS-1:0] sample,
   output logic                                  block_end
);
   import sosc_pkg::*;

   localparam quarter_table_type QuarterRom = build_quarter_table();

   logic [FREQ_BITS-1:0]       freq_ff;
   logic [RATE_BITS-1:0]       rate_ff;
   logic [PHASE_BITS-1:0]      phase_ff;
   logic [PHASE_BITS-1:0]      step_ff;
   logic [DIVIDEND_BITS-1:0]   dividend_ff;
   logic [RATE_BITS-1:0]       divisor_ff;
   logic [RATE_BITS-1:0]       rem_ff;
   logic [PHASE_BITS-1:0]      quot_ff;
   logic [ENTRY_BITS-1:0]      rom_ff;
   logic                       neg_ff;
   logic                       last_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                       block_end_ff;

   logic [FREQ_CLAMP_BITS-1:0] freq_clamped;
   logic [RATE_BITS-1:0]       rate_clamped;
   logic [RATE_BITS:0]         rem_shift;
   logic                       rem_fits;
   logic [RATE_BITS-1:0]       rem_in;
   logic [1:0]                 quad;
   logic [TABLE_BITS-1:0]      index;
   logic [ROM_ADDR_BITS-1:0]   rom_addr;
   logic [SAMPLE_BITS-1:0]     magnitude;

   always_comb begin
      if (freq_ff < FREQ_MIN) begin
         freq_clamped = FREQ_CLAMP_BITS'(FREQ_MIN);
      end else if (freq_ff > FREQ_MAX) begin
         freq_clamped = FREQ_CLAMP_BITS'(FREQ_MAX);
      end else begin
         freq_clamped = freq_ff[FREQ_CLAMP_BITS-1:0];
      end
      rate_clamped = (rate_ff < RATE_MIN) ? RATE_MIN : rate_ff;
   end

   assign rem_shift = {rem_ff, dividend_ff[DIVIDEND_BITS-1]};
   assign rem_fits  = rem_shift >= {1'b0, divisor_ff};
   assign rem_in    = rem_fits ? RATE_BITS'(rem_shift - {1'b0, divisor_ff})
                               : rem_shift[RATE_BITS-1:0];

   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign index    = phase_ff[PHASE_BITS-3 -: TABLE_BITS];
   assign rom_addr = quad[0] ? ROM_ADDR_BITS'((1 << TABLE_BITS) - int'(index))
                             : {1'b0, index};
   assign magnitude = {1'b0, rom_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= FREQ_RESET;
         rate_ff  <= RATE_RESET;
         phase_ff <= '0;
         step_ff  <= STEP_RESET;
      end else begin
         if (csr_we && csr_index == CSR_FREQUENCY) begin
            freq_ff <= csr_wdata[FREQ_BITS-1:0];
         end
         if (csr_we && csr_index == CSR_SAMPLE_RATE) begin
            rate_ff <= csr_wdata[RATE_BITS-1:0];
         end
         if (cmd.accept) begin
            phase_ff <= phase_ff + step_ff;
         end
         if (cmd.step_load) begin
            step_ff <= quot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dividend_ff <= {freq_clamped, {PHASE_BITS{1'b0}}};
         divisor_ff  <= rate_clamped;
         rem_ff      <= '0;
         quot_ff     <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[DIVIDEND_BITS-2:0], 1'b0};
         rem_ff      <= rem_in;
         quot_ff     <= {quot_ff[PHASE_BITS-2:0], rem_fits};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         rom_ff       <= QuarterRom[rom_addr];
         neg_ff       <= quad[1];
         last_ff      <= end_of_block;
         sample_ff    <= neg_ff ? -signed'(magnitude) : signed'(magnitude);
         block_end_ff <= last_ff;
      end
   end

   assign sample    = sample_ff;
   assign block_end = block_end_ff;

endmodule

/* src/sine_oscillator_core.sv */
// Top level of the sine oscillator: stream channels, configuration port and the
// controller and datapath instances. Depends on sosc_pkg, sosc_ctrl and sosc_datapath.
//
// Each request transaction on the req_ channel yields one response transaction on the
// rsp_ channel carrying a stereo frame: both samples hold the same Q1.15 sine of the
// current phase, and rsp_tlast repeats the request's end-of-block flag (req_tdata bit 0).
// The phase then advances by the phase step.
// A request passes a ROM read stage and the output register before its response is
// valid; one request is accepted per cycle while the receiver keeps up and no division
// runs. A stalled response freezes the two stages and deasserts req_tready.
// A write on the csr_ port stores frequency or sample rate and starts a restoring
// division, one quotient bit per cycle; requests are held off until the new phase
// step is loaded. The phase itself is kept across writes.
// Reset clears the phase, empties the pipeline and restores 440 Hz at 48 kHz, whose
// step is available at once.
module sine_oscillator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [sosc_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // end_of_block, zero pad
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [sosc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // left_sample, right_sample
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [sosc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sosc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import sosc_pkg::*;

   ctrl_cmd_type                 cmd;
   logic signed [SAMPLE_BITS-1:0] sample;

   sosc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sosc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .end_of_block (req_tdata[0]),
      .sample       (sample),
      .block_end    (rsp_tlast)
   );

   assign rsp_tdata = {sample, sample};

endmodule

/* tb/sv/sine_oscillator_core_test.sv */
// Self-checking testbench for sine_oscillator_core: stereo sine frames checked against a
// phase-accumulator predictor with its own quarter-wave table. Depends on sosc_pkg and sine_oscillator_core.
`timescale 1ns / 100ps

module sine_oscillator_core_test;

   import sosc_pkg::*;

   localparam int QUARTER      = 1 << TABLE_BITS;
   localparam int STEP_SETTLE  = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CALM_FROM    = 1500;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
      logic                   block_end;
   } frame_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_DATA_BITS-1:0]    req_tdata;   // end_of_block, zero pad
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;   // left_sample, right_sample
   logic                        rsp_tlast;
   logic                        csr_we;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   int                          sine_quarter [0:QUARTER];
   logic [PHASE_BITS-1:0]       osc_phase;
   logic [PHASE_BITS-1:0]       osc_step;
   logic [FREQ_BITS-1:0]        osc_frequency;
   logic [RATE_BITS-1:0]        osc_rate;
   frame_type                   pending_frames [$];
   int                          error_count = 0;
   int                          frames_sent = 0;
   int                          sender_steady = 0;
   bit                          calm = 1'b0;

   sine_oscillator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   // Amplitude of sin(pi/2 * k / QUARTER) from a truncated Taylor series in Q30.
   function automatic int quarter_entry(int k);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] term;
      logic [63:0] mag;
      longint      acc;
      angle    = (64'd1686629713 * 64'(k)) >> TABLE_BITS;
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      acc      = longint'(angle);
      for (int n = 1; n < 10; n++) begin
         term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      mag = (64'(acc) * 64'(AMP) + 64'd536870912) >> 30;
      if (mag > 64'(AMP)) begin
         mag = 64'(AMP);
      end
      return int'(mag);
   endfunction

   function automatic logic [PHASE_BITS-1:0] phase_increment(logic [FREQ_BITS-1:0] frequency,
                                                             logic [RATE_BITS-1:0] rate);
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] q;
      f = 64'(frequency);
      r = 64'(rate);
      if (f < 64'(FREQ_MIN)) begin
         f = 64'(FREQ_MIN);
      end
      if (f > 64'(FREQ_MAX)) begin
         f = 64'(FREQ_MAX);
      end
      if (r < 64'(RATE_MIN)) begin
         r = 64'(RATE_MIN);
      end
      q = (f << PHASE_BITS) / r;
      return q[PHASE_BITS-1:0];
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sine_of_phase(logic [PHASE_BITS-1:0] phase);
      logic [TABLE_BITS+1:0] top;
      logic [TABLE_BITS:0]   idx;
      int                    value;
      top = phase[PHASE_BITS-1 -: TABLE_BITS+2];
      idx = {1'b0, top[TABLE_BITS-1:0]};
      if (top[TABLE_BITS]) begin
         idx = (TABLE_BITS+1)'(QUARTER - int'(idx));
      end
      value = sine_quarter[idx];
      if (top[TABLE_BITS+1]) begin
         value = -value;
      end
      return value[SAMPLE_BITS-1:0];
   endfunction

   task automatic send_frame(logic block_end);
      frame_type frame;
      @(negedge clock);
      if (sender_steady > 0) begin
         sender_steady--;
      end else if (!calm) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               req_tvalid = 1'b0;
               repeat ($urandom_range(1, 5)) @(negedge clock);
            end
            3: begin
               sender_steady = $urandom_range(20, 80);
            end
            default: begin
            end
         endcase
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_BITS-1){1'b0}}, block_end};
      do @(posedge clock); while (!req_tready);
      frame.left      = sine_of_phase(osc_phase);
      frame.right     = frame.left;
      frame.block_end = block_end;
      pending_frames.push_back(frame);
      osc_phase = osc_phase + osc_step;
      frames_sent++;
   endtask

   task automatic send_run(int count);
      for (int i = 0; i < count; i++) begin
         send_frame(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      drain();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (index == CSR_FREQUENCY) begin
         osc_frequency = value[FREQ_BITS-1:0];
      end else begin
         osc_rate = value[RATE_BITS-1:0];
      end
      osc_step = phase_increment(osc_frequency, osc_rate);
      // The new step is derived by a serial division while requests are held off.
      repeat (STEP_SETTLE) @(posedge clock);
   endtask

   task automatic test_reset_step();
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b1);
      send_frame(1'b0);
   endtask

   // A quarter-turn step walks through all four quadrants at one table index.
   task automatic test_quadrants();
      write_register(CSR_SAMPLE_RATE, 18'd48000);
      write_register(CSR_FREQUENCY, 18'd12000);
      send_run(6);
      write_register(CSR_SAMPLE_RATE, 18'd40000);
      write_register(CSR_FREQUENCY, 18'd20000);
      send_run(2);
   endtask

   task automatic test_frequency_limits();
      write_register(CSR_FREQUENCY, 18'd0);
      send_run(2);
      write_register(CSR_FREQUENCY, 18'd65535);
      send_run(2);
      // Bits above the frequency field are dropped.
      write_register(CSR_FREQUENCY, 18'h30000 | 18'd300);
      send_run(2);
   endtask

   task automatic test_sample_rate_limits();
      write_register(CSR_SAMPLE_RATE, 18'd0);
      send_run(2);
      write_register(CSR_SAMPLE_RATE, 18'h3FFFF);
      send_run(2);
      write_register(CSR_FREQUENCY, 18'd20000);
      write_register(CSR_SAMPLE_RATE, 18'd1000);
      send_run(2);
      write_register(CSR_SAMPLE_RATE, 18'd192000);
      send_run(2);
   endtask

   task automatic test_random_settings();
      int                      start;
      int                      count;
      logic [CSR_DATA_BITS-1:0] value;
      start = frames_sent;
      while (frames_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 1) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 4))
                     0: value = 18'd0;
                     1: value = 18'd1;
                     2: value = 18'd20000;
                     3: value = 18'd20001;
                     default: value = 18'd65535;
                  endcase
               end
               1: value = 18'($urandom_range(0, 18'h3FFFF));
               default: value = 18'($urandom_range(1, 20000));
            endcase
            write_register(CSR_FREQUENCY, value);
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 4))
                     0: value = 18'd0;
                     1: value = 18'd1;
                     2: value = 18'd1000;
                     3: value = 18'd192000;
                     default: value = 18'h3FFFF;
                  endcase
               end
               1: value = 18'($urandom_range(0, 18'h3FFFF));
               default: value = 18'($urandom_range(1000, 192000));
            endcase
            write_register(CSR_SAMPLE_RATE, value);
         end
         calm  = (frames_sent - start >= CALM_FROM);
         count = $urandom_range(10, 120);
         send_run(count);
      end
   endtask

   initial begin : response_idling
      int hold;
      int steady;
      hold       = 0;
      steady     = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (calm || steady > 0) begin
            rsp_tready = 1'b1;
            if (steady > 0) begin
               steady--;
            end
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  rsp_tready = 1'b0;
                  hold       = $urandom_range(1, 5) - 1;
               end
               2: begin
                  rsp_tready = 1'b1;
                  steady     = $urandom_range(20, 80);
               end
               default: rsp_tready = 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_frame
      frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got left %0d right %0d last %0b",
                     $time, $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]), rsp_tlast);
            error_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_tdata[15:0] !== want.left) begin
               $display("%0t: left_sample expected %0d, got %0d", $time,
                        $signed(want.left), $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.right) begin
               $display("%0t: right_sample expected %0d, got %0d", $time,
                        $signed(want.right), $signed(rsp_tdata[31:16]));
               error_count++;
            end
            if (rsp_tlast !== want.block_end) begin
               $display("%0t: block_end expected %0b, got %0b", $time,
                        want.block_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_FREQUENCY;
      csr_wdata  = '0;
      for (int k = 0; k <= QUARTER; k++) begin
         sine_quarter[k] = quarter_entry(k);
      end
      osc_frequency = FREQ_RESET;
      osc_rate      = RATE_RESET;
      osc_phase     = '0;
      osc_step      = phase_increment(osc_frequency, osc_rate);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_step();
      test_quadrants();
      test_frequency_limits();
      test_sample_rate_limits();
      test_random_settings();
      drain();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
